[sv/gbn_pkg.sv]
// Shared constants, codes and types of the Go-Back-N sender.
// No dependencies; gbn_buf and go_back_n_sender refer to this package.
package gbn_pkg;

    localparam int BUF_DEPTH   = 64;
    localparam int ADDR_W      = $clog2(BUF_DEPTH);
    localparam int WINDOW_MAX  = 8;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int SEQ_W       = 32;

    localparam logic [1:0] FUNC_NEW  = 2'd0;
    localparam logic [1:0] FUNC_ACK  = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;
    localparam logic [1:0] FUNC_NOP  = 2'd3;

    localparam logic [1:0] CFG_WINDOW  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;

    localparam logic [3:0]  WINDOW_RESET  = 4'd8;
    localparam logic [15:0] TIMEOUT_RESET = 16'd20;

    typedef struct packed {
        logic [63:0] pa;
        logic [63:0] pb;
        logic [31:0] pc;
        logic [31:0] chk;
    } buf_entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        buf_entry_t        data;
    } buf_wr_t;

endpackage

[sv/gbn_csum.sv]
// Packet checksum: two 32-bit header terms plus the 20 payload bytes read as signed.
// Depends on nothing but its ports.
module gbn_csum (
    input  logic [31:0] term_a,
    input  logic [31:0] term_b,
    input  logic [63:0] pa,
    input  logic [63:0] pb,
    input  logic [31:0] pc,
    output logic [31:0] sum
);

    logic signed [7:0]  bytes [20];
    logic signed [10:0] grp [4];
    logic signed [12:0] total;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            bytes[i]     = pa[8*i +: 8];
            bytes[8 + i] = pb[8*i +: 8];
        end
        for (int i = 0; i < 4; i++)
        begin
            bytes[16 + i] = pc[8*i +: 8];
        end
        for (int g = 0; g < 4; g++)
        begin
            grp[g] = '0;
            for (int k = 0; k < 5; k++)
            begin
                grp[g] = grp[g] + 11'(bytes[5*g + k]);
            end
        end
        total = 13'(grp[0]) + 13'(grp[1]) + 13'(grp[2]) + 13'(grp[3]);
    end

    assign sum = term_a + term_b + 32'(total);

endmodule

[sv/gbn_buf.sv]
// Packet buffer: one write port and one read port with registered read data.
// Depends on gbn_pkg for the entry and write request types.
module gbn_buf (
    input  logic                      clk,
    input  gbn_pkg::buf_wr_t          wr,
    input  logic                      rd_en,
    input  logic [gbn_pkg::ADDR_W-1:0] rd_addr,
    output gbn_pkg::buf_entry_t       rd_data
);

    gbn_pkg::buf_entry_t mem [gbn_pkg::BUF_DEPTH];
    gbn_pkg::buf_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/go_back_n_sender.sv]
// Go-Back-N sender top level: request sequencer, window and timer state.
// Depends on gbn_pkg, gbn_csum and gbn_buf.
//
// Input requests (func, ACK fields, payload) arrive on in_valid/in_stall; a
// request is taken only while the sender is idle, and in_stall stays high
// while one is in work. Func 0 stores a message and sends what the window
// allows, or sends one status packet if the buffer is full; func 1 takes an
// ACK, func 2 is one timer tick. Each packet sent leaves on out_valid and
// out_stall from an output register; last marks the final packet caused by
// a request. The request is registered and executed in S_EXEC; each packet
// then takes one buffer read in S_PUMP and one output load in S_WAIT, with
// at most eight packets per request. When the receiver stalls, the sequencer
// waits with the read data held until the output register frees.
// Configuration writes on cfg_valid/cfg_ready are always taken. Reset clears
// the sequence numbers and timer and sets window 8 and timeout 20; the
// buffer needs no clearing since only written entries are ever read.
module go_back_n_sender (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [31:0]        in_seq,
    input  logic [31:0]        in_ack,
    input  logic signed [31:0] in_checksum,
    input  logic [63:0]        payload_a,
    input  logic [63:0]        payload_b,
    input  logic [31:0]        payload_c,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               status,
    output logic [31:0]        out_seq,
    output logic [63:0]        out_payload_a,
    output logic [63:0]        out_payload_b,
    output logic [31:0]        out_payload_c,
    output logic signed [31:0] out_checksum,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_PUMP = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  func_reg;
    logic [31:0] seq_in_reg, ack_in_reg, chk_in_reg;
    logic [63:0] pa_reg, pb_reg;
    logic [31:0] pc_reg;
    logic [3:0]  window_reg;
    logic [15:0] timeout_reg;
    logic [31:0] base_reg, base_next;
    logic [31:0] send_reg, send_next;
    logic [31:0] new_reg, new_next;
    logic [31:0] cur_reg, cur_next;
    logic [31:0] emit_reg, emit_next;
    logic [15:0] tcnt_reg, tcnt_next;
    logic        trun_reg, trun_next;
    logic        resend_reg, resend_next;
    logic [gbn_pkg::CNT_W-1:0] n_reg, n_next;
    logic        out_valid_reg, out_valid_next;
    logic        status_reg, status_next;
    logic        last_reg, last_next;
    logic [31:0] out_seq_reg, out_seq_next;
    gbn_pkg::buf_entry_t out_data_reg, out_data_next;

    logic [3:0]  eff_w;
    logic [15:0] start_val;
    logic [15:0] tdec;
    logic [31:0] term_a, term_b, csum;
    logic        pump_go, resend_go, more, load_ok, ack_ok, full;
    gbn_pkg::buf_wr_t    wr;
    logic                rd_en;
    logic [gbn_pkg::ADDR_W-1:0] rd_addr;
    gbn_pkg::buf_entry_t rd_data;

    assign eff_w = (window_reg == 4'd0) ? 4'd1 :
                   (window_reg > 4'(gbn_pkg::WINDOW_MAX)) ? 4'(gbn_pkg::WINDOW_MAX) :
                   window_reg;
    assign start_val = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    assign tdec      = (tcnt_reg == 16'd0) ? 16'd0 : tcnt_reg - 16'd1;

    assign term_a = (func_reg == gbn_pkg::FUNC_NEW) ? new_reg : seq_in_reg;
    assign term_b = (func_reg == gbn_pkg::FUNC_NEW) ? new_reg : ack_in_reg;

    gbn_csum u_csum (
        .term_a (term_a),
        .term_b (term_b),
        .pa     (pa_reg),
        .pb     (pb_reg),
        .pc     (pc_reg),
        .sum    (csum)
    );

    gbn_buf u_buf (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pump_go = ((send_reg - base_reg) < {28'd0, eff_w}) && (send_reg != new_reg)
                     && (n_reg < gbn_pkg::CNT_W'(gbn_pkg::MAX_RESULTS));
    assign resend_go = (cur_reg != send_reg)
                       && (n_reg < gbn_pkg::CNT_W'(gbn_pkg::MAX_RESULTS));
    assign more    = resend_reg ? resend_go : pump_go;
    assign load_ok = !out_valid_reg || !out_stall;
    assign ack_ok  = (csum == chk_in_reg) && ((ack_in_reg - base_reg) < (send_reg - base_reg));
    assign full    = (new_reg - base_reg) >= 32'(gbn_pkg::BUF_DEPTH);

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        send_next      = send_reg;
        new_next       = new_reg;
        cur_next       = cur_reg;
        emit_next      = emit_reg;
        tcnt_next      = tcnt_reg;
        trun_next      = trun_reg;
        resend_next    = resend_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        last_next      = last_reg;
        out_seq_next   = out_seq_reg;
        out_data_next  = out_data_reg;
        wr.en          = 1'b0;
        wr.addr        = new_reg[gbn_pkg::ADDR_W-1:0];
        wr.data.pa     = pa_reg;
        wr.data.pb     = pb_reg;
        wr.data.pc     = pc_reg;
        wr.data.chk    = csum;
        rd_en          = 1'b0;
        rd_addr        = send_reg[gbn_pkg::ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                n_next      = '0;
                resend_next = 1'b0;
                state_next  = S_IDLE;
                unique case (func_reg)
                    gbn_pkg::FUNC_NEW:
                    begin
                        if (full)
                        begin
                            if (load_ok)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = 1'b1;
                                last_next      = 1'b1;
                                out_seq_next   = '0;
                                out_data_next  = '0;
                            end
                            else
                            begin
                                state_next = S_EXEC;
                            end
                        end
                        else
                        begin
                            wr.en      = 1'b1;
                            new_next   = new_reg + 32'd1;
                            state_next = S_PUMP;
                        end
                    end
                    gbn_pkg::FUNC_ACK:
                    begin
                        if (ack_ok)
                        begin
                            base_next = ack_in_reg + 32'd1;
                            if (ack_in_reg + 32'd1 == send_reg)
                            begin
                                trun_next = 1'b0;
                                tcnt_next = '0;
                            end
                            else
                            begin
                                trun_next = 1'b1;
                                tcnt_next = start_val;
                            end
                            state_next = S_PUMP;
                        end
                    end
                    gbn_pkg::FUNC_TICK:
                    begin
                        if (trun_reg)
                        begin
                            if (tdec == 16'd0)
                            begin
                                tcnt_next   = start_val;
                                cur_next    = base_reg;
                                resend_next = 1'b1;
                                state_next  = S_PUMP;
                            end
                            else
                            begin
                                tcnt_next = tdec;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PUMP:
            begin
                state_next = S_IDLE;
                if (resend_reg)
                begin
                    if (resend_go)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = cur_reg[gbn_pkg::ADDR_W-1:0];
                        emit_next  = cur_reg;
                        cur_next   = cur_reg + 32'd1;
                        n_next     = n_reg + 1'b1;
                        state_next = S_WAIT;
                    end
                end
                else if (pump_go)
                begin
                    if (send_reg == base_reg)
                    begin
                        trun_next = 1'b1;
                        tcnt_next = start_val;
                    end
                    rd_en      = 1'b1;
                    emit_next  = send_reg;
                    send_next  = send_reg + 32'd1;
                    n_next     = n_reg + 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    status_next    = 1'b0;
                    last_next      = !more;
                    out_seq_next   = emit_reg;
                    out_data_next  = rd_data;
                    state_next     = S_PUMP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= gbn_pkg::WINDOW_RESET;
            timeout_reg   <= gbn_pkg::TIMEOUT_RESET;
            base_reg      <= '0;
            send_reg      <= '0;
            new_reg       <= '0;
            tcnt_reg      <= '0;
            trun_reg      <= 1'b0;
            resend_reg    <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            send_reg      <= send_next;
            new_reg       <= new_next;
            tcnt_reg      <= tcnt_next;
            trun_reg      <= trun_next;
            resend_reg    <= resend_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_addr == gbn_pkg::CFG_WINDOW)
            begin
                window_reg <= cfg_data[3:0];
            end
            if (cfg_valid && cfg_addr == gbn_pkg::CFG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg   <= func;
            seq_in_reg <= in_seq;
            ack_in_reg <= in_ack;
            chk_in_reg <= in_checksum;
            pa_reg     <= payload_a;
            pb_reg     <= payload_b;
            pc_reg     <= payload_c;
        end
        cur_reg      <= cur_next;
        emit_reg     <= emit_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
        out_seq_reg  <= out_seq_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign last          = last_reg;
    assign out_seq       = out_seq_reg;
    assign out_payload_a = out_data_reg.pa;
    assign out_payload_b = out_data_reg.pb;
    assign out_payload_c = out_data_reg.pc;
    assign out_checksum  = out_data_reg.chk;

    a_send_behind_new: assert property (@(posedge clk) disable iff (!rst_n)
        (send_reg - base_reg) <= (new_reg - base_reg))
        else $error("send pointer passed the newest message");

    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (new_reg - base_reg) <= 32'(gbn_pkg::BUF_DEPTH))
        else $error("buffer holds more messages than its depth");

    a_wait_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT && $past(state_reg) != S_WAIT) |-> $past(rd_en))
        else $error("output load without a buffer read");

    a_burst_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= gbn_pkg::CNT_W'(gbn_pkg::MAX_RESULTS))
        else $error("too many packets for one request");

endmodule
